@@ rtl/lcdnw_pkg.sv @@
// Package for the LCD nibble write sequencer: shared types and constants.
// No dependencies; the two interfaces do not use it, the other files refer to it by scoped name.
package lcdnw_pkg;

    // Request action codes.
    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_CHAR = 2'd1;
    localparam logic [1:0] ACT_NUM  = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Display commands and character constants.
    localparam logic [7:0] CMD_DECREMENT = 8'h04;
    localparam logic [7:0] CMD_INCREMENT = 8'h06;
    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [4:0] RADIX         = 5'd10;

    // Configuration port.
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned DATA_W     = 32;
    localparam logic        REG_PULSE_WAIT = 1'b0;
    localparam logic [15:0] PULSE_WAIT_RESET = 16'd1000;

    // One byte handed from the sequencer to the byte transmitter.
    typedef struct packed {
        logic [7:0] data;
        logic       rs;
        logic       last;
    } byte_req_t;

endpackage

@@ rtl/lcdnw_req_if.sv @@
// Request channel of the LCD nibble write sequencer: action and value.
// Depends on nothing; the value width follows VALUE_BITS.
interface lcdnw_req_if #(
    parameter int unsigned VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

@@ rtl/lcdnw_port_if.sv @@
// Port state channel of the LCD nibble write sequencer.
// Depends on nothing; carries one pin state and its hold time per item.
interface lcdnw_port_if;
    logic        valid;
    logic        ready;
    logic [7:0]  port_value;
    logic [15:0] wait_us;
    logic        last;

    modport source (output valid, output port_value, output wait_us, output last, input ready);
    modport sink   (input valid, input port_value, input wait_us, input last, output ready);
endinterface

@@ rtl/lcd_nibble_write_sequencer_top.sv @@
// Top level of the LCD nibble write sequencer: request sequencer, divider,
// byte transmitter and configuration port. Depends on lcdnw_pkg and both interfaces.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+-----------------------------
//   req      | in        | valid/ready   | action, value
//   lcd      | out       | valid/ready   | port_value, wait_us, last
//   apb      | in        | psel/penable  | paddr, pwdata -> prdata
//
// Each byte is six port states, one per cycle while lcd is ready; valid then drops
// before the next byte starts, for command, character and number items alike.
// The shared divide-by-ten unit runs while the previous byte goes out, so the
// byte stream never waits on it.
// Reset clears all control state; pulse_wait_us returns to 1000.
// A stall on lcd holds the current port state and stops the sequencer.
module lcd_nibble_write_sequencer_top #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lcdnw_req_if.sink                     req,
    lcdnw_port_if.source                  lcd,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcdnw_pkg::ADDR_W-1:0]  paddr,
    input  logic [lcdnw_pkg::DATA_W-1:0]  pwdata,
    output logic [lcdnw_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [15:0]             pulse_wait_us;
    logic                    tx_start;
    logic                    tx_busy;
    lcdnw_pkg::byte_req_t    tx_req;
    logic                    div_start;
    logic                    div_busy;
    logic [VALUE_BITS-1:0]   div_dividend;
    logic [VALUE_BITS-1:0]   div_quot;
    logic [3:0]              div_rem;
    logic                    req_accept;

    assign req.ready  = (state_reg == S_IDLE) && !tx_busy;
    assign req_accept = req.valid && req.ready;

    always_comb
    begin
        state_next   = state_reg;
        tx_start     = 1'b0;
        tx_req.data  = lcdnw_pkg::CMD_INCREMENT;
        tx_req.rs    = 1'b0;
        tx_req.last  = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_quot;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    case (req.action)
                        lcdnw_pkg::ACT_CMD, lcdnw_pkg::ACT_CHAR:
                        begin
                            tx_start    = 1'b1;
                            tx_req.data = req.value[7:0];
                            tx_req.rs   = (req.action == lcdnw_pkg::ACT_CHAR);
                            tx_req.last = 1'b1;
                        end
                        lcdnw_pkg::ACT_NUM:
                        begin
                            tx_start     = 1'b1;
                            tx_req.data  = lcdnw_pkg::CMD_DECREMENT;
                            div_start    = 1'b1;
                            div_dividend = req.value;
                            state_next   = S_DIV;
                        end
                        default:
                        begin
                            // Unused action code: the item is dropped.
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (!div_busy && !tx_busy)
                begin
                    tx_start    = 1'b1;
                    tx_req.data = lcdnw_pkg::ASCII_ZERO + {4'd0, div_rem};
                    tx_req.rs   = 1'b1;
                    // Zero prints a single digit, since the first pass always emits one.
                    if (div_quot == '0)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            S_TAIL:
            begin
                if (!tx_busy)
                begin
                    tx_start    = 1'b1;
                    tx_req.data = lcdnw_pkg::CMD_INCREMENT;
                    tx_req.last = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    lcdnw_div10 #(
        .W (VALUE_BITS)
    ) u_div10 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    lcdnw_byte_tx u_byte_tx (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (tx_start),
        .req_in        (tx_req),
        .pulse_wait_us (pulse_wait_us),
        .busy          (tx_busy),
        .lcd           (lcd)
    );

    lcdnw_apb u_apb (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pulse_wait_us (pulse_wait_us)
    );

endmodule

@@ rtl/lcdnw_apb.sv @@
// APB-style configuration register file holding the enable pulse hold time.
// Depends on lcdnw_pkg.
module lcdnw_apb (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcdnw_pkg::ADDR_W-1:0]        paddr,
    input  logic [lcdnw_pkg::DATA_W-1:0]        pwdata,
    output logic [lcdnw_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    output logic [15:0]                         pulse_wait_us
);

    logic [15:0] pulse_wait_reg;
    logic [15:0] pulse_wait_next;
    logic        hit;

    assign pready = 1'b1;
    assign hit    = (paddr[lcdnw_pkg::ADDR_W-1:2] == lcdnw_pkg::REG_PULSE_WAIT);

    always_comb
    begin
        pulse_wait_next = pulse_wait_reg;
        if (psel && penable && pwrite && hit)
        begin
            pulse_wait_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_wait_reg <= lcdnw_pkg::PULSE_WAIT_RESET;
        end
        else
        begin
            pulse_wait_reg <= pulse_wait_next;
        end
    end

    assign prdata        = hit ? {16'd0, pulse_wait_reg} : '0;
    assign pulse_wait_us = pulse_wait_reg;

endmodule

@@ rtl/lcdnw_div10.sv @@
// Divide-by-ten unit: reciprocal multiplication, then the remainder from the quotient.
// Depends on lcdnw_pkg for the radix.
module lcdnw_div10 #(
    parameter int unsigned W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    output logic         busy,
    output logic [W-1:0] quot,
    output logic [3:0]   rem
);

    localparam int unsigned SHIFT   = W + 3;
    localparam int unsigned SCALE_W = W + 4;
    localparam int unsigned PROD_W  = 2 * W;

    // ceil(2^(W+3) / 10) fits in W bits and gives an exact quotient for every W-bit dividend.
    localparam logic [SCALE_W-1:0] SCALE      = {1'b1, {SHIFT{1'b0}}};
    localparam logic [SCALE_W-1:0] RECIP_WIDE =
        (SCALE + SCALE_W'(9)) / SCALE_W'(lcdnw_pkg::RADIX);
    localparam logic [W-1:0]       RECIP      = RECIP_WIDE[W-1:0];

    logic              busy_reg, busy_next;
    logic              step_reg, step_next;
    logic [W-1:0]      num_reg, num_next;
    logic [W-1:0]      quot_reg, quot_next;
    logic [3:0]        rem_reg, rem_next;
    logic [PROD_W-1:0] product;

    assign product = PROD_W'(num_reg) * PROD_W'(RECIP);

    // First step forms the quotient; second step takes the remainder from the low bits.
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 1'b0;
            num_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (!step_reg)
            begin
                quot_next = {3'b000, product[PROD_W-1:SHIFT]};
                step_next = 1'b1;
            end
            else
            begin
                rem_next  = num_reg[3:0] - {quot_reg[0], 3'b000} - {quot_reg[2:0], 1'b0};
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/lcdnw_byte_tx.sv @@
// Byte transmitter: turns one byte into six registered port states.
// Depends on lcdnw_pkg and lcdnw_port_if.
module lcdnw_byte_tx (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lcdnw_pkg::byte_req_t  req_in,
    input  logic [15:0]           pulse_wait_us,
    output logic                  busy,
    lcdnw_port_if.source          lcd
);

    logic                 valid_reg, valid_next;
    logic                 half_reg, half_next;
    logic [1:0]           phase_reg, phase_next;
    lcdnw_pkg::byte_req_t byte_reg, byte_next;
    logic [3:0]           nibble;
    logic                 enable;
    logic                 accept;

    assign accept = valid_reg && lcd.ready;

    // Phase 0 is setup, 1 is enable high, 2 is enable low; half selects the nibble.
    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        phase_next = phase_reg;
        byte_next  = byte_reg;
        if (start)
        begin
            valid_next = 1'b1;
            half_next  = 1'b0;
            phase_next = 2'd0;
            byte_next  = req_in;
        end
        else if (accept)
        begin
            if (phase_reg == 2'd2)
            begin
                phase_next = 2'd0;
                half_next  = 1'b1;
                if (half_reg)
                begin
                    valid_next = 1'b0;
                end
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign nibble = half_reg ? byte_reg.data[3:0] : byte_reg.data[7:4];
    assign enable = (phase_reg == 2'd1);

    assign lcd.valid      = valid_reg;
    assign lcd.port_value = {nibble, 1'b0, enable, 1'b0, byte_reg.rs};
    assign lcd.wait_us    = (phase_reg == 2'd0) ? 16'd0 : pulse_wait_us;
    assign lcd.last       = byte_reg.last && half_reg && (phase_reg == 2'd2);
    assign busy           = valid_reg;

endmodule

@@ rtl/lcdnw_checker.sv @@
// Port-level checks for the LCD nibble write sequencer, bound to the top level.
// Depends on lcdnw_pkg and lcd_nibble_write_sequencer_top.
module lcdnw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_action,
    input logic       lcd_valid,
    input logic [7:0] lcd_port_value,
    input logic [15:0] lcd_wait_us
);

    // A new item is never taken while a port state is still on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        lcd_valid |-> !req_ready)
        else $error("request accepted while a port state is pending");

    // An ignored action code produces no port state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_action == lcdnw_pkg::ACT_NONE) |=> !lcd_valid)
        else $error("ignored request produced output");

    // Any other item starts at once with a setup state: enable low, no hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_action != lcdnw_pkg::ACT_NONE)
        |=> (lcd_valid && !lcd_port_value[2] && lcd_wait_us == 16'd0))
        else $error("request did not start with a setup state");

    // The read/write line is never driven high.
    assert property (@(posedge clk) disable iff (!rst_n)
        lcd_valid |-> !lcd_port_value[1])
        else $error("read/write bit set on a port state");

endmodule

bind lcd_nibble_write_sequencer_top lcdnw_checker u_lcdnw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_action     (req.action),
    .lcd_valid      (lcd.valid),
    .lcd_port_value (lcd.port_value),
    .lcd_wait_us    (lcd.wait_us)
);

@@ sim/lcd_nibble_write_sequencer_top_test.sv @@
// Self-checking testbench for lcd_nibble_write_sequencer_top: directed and random requests and
// pin-state stalls, with the pulse wait register rewritten between phases.
// Depends on lcdnw_pkg, the two channel interfaces of the block and its top level.
module lcd_nibble_write_sequencer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VALUE_BITS    = 16;
    localparam int unsigned MAX_GAP       = 12;
    localparam int unsigned SETTLE_CYCLES = 120;
    localparam int unsigned RANDOM_PHASE  = 40;
    localparam logic [7:0]  ENABLE_PIN    = 8'h04;
    localparam logic        RS_DATA       = 1'b1;
    localparam logic        RS_COMMAND    = 1'b0;

    typedef struct packed {
        logic [7:0]  port_value;
        logic [15:0] wait_us;
        logic        last;
    } pin_state_t;

    class lcd_pin_scoreboard;
        pin_state_t  pending_pins[$];
        logic [15:0] pulse_wait;
        int unsigned errors;

        function new();
            pulse_wait = lcdnw_pkg::PULSE_WAIT_RESET;
            errors     = 0;
        endfunction

        function int unsigned outstanding();
            return pending_pins.size();
        endfunction

        // One nibble is setup, enable high, enable low; only the edges hold.
        function void add_nibble(ref pin_state_t burst[$], input logic [3:0] nib,
                                 input logic rs);
            pin_state_t pin;
            pin.port_value = {nib, 3'b000, rs};
            pin.last       = 1'b0;
            pin.wait_us    = '0;
            burst.push_back(pin);
            pin.port_value = pin.port_value | ENABLE_PIN;
            pin.wait_us    = pulse_wait;
            burst.push_back(pin);
            pin.port_value = {nib, 3'b000, rs};
            burst.push_back(pin);
        endfunction

        function void add_byte(ref pin_state_t burst[$], input logic [7:0] data,
                               input logic rs);
            add_nibble(burst, data[7:4], rs);
            add_nibble(burst, data[3:0], rs);
        endfunction

        function void note_request(logic [1:0] action, logic [VALUE_BITS-1:0] value);
            pin_state_t            burst[$];
            logic [VALUE_BITS-1:0] num;
            case (action)
                lcdnw_pkg::ACT_CMD:  add_byte(burst, value[7:0], RS_COMMAND);
                lcdnw_pkg::ACT_CHAR: add_byte(burst, value[7:0], RS_DATA);
                lcdnw_pkg::ACT_NUM:
                begin
                    // Digits go out least significant first with the cursor moving left.
                    num = value;
                    add_byte(burst, lcdnw_pkg::CMD_DECREMENT, RS_COMMAND);
                    if (num == 0)
                        add_byte(burst, lcdnw_pkg::ASCII_ZERO, RS_DATA);
                    while (num != 0)
                    begin
                        add_byte(burst, lcdnw_pkg::ASCII_ZERO + 8'(num % lcdnw_pkg::RADIX),
                                 RS_DATA);
                        num = num / lcdnw_pkg::RADIX;
                    end
                    add_byte(burst, lcdnw_pkg::CMD_INCREMENT, RS_COMMAND);
                end
                default: ;
            endcase
            if (burst.size() != 0)
                burst[burst.size()-1].last = 1'b1;
            foreach (burst[i])
                pending_pins.push_back(burst[i]);
        endfunction

        function void check_pin_state(logic [7:0] port_value, logic [15:0] wait_us,
                                      logic last);
            pin_state_t want;
            if (pending_pins.size() == 0)
            begin
                $error("unexpected pin state: port_value %h, wait_us %0d, last %b",
                       port_value, wait_us, last);
                errors++;
                return;
            end
            want = pending_pins.pop_front();
            if (port_value !== want.port_value)
            begin
                $error("port_value: expected %h, got %h", want.port_value, port_value);
                errors++;
            end
            if (wait_us !== want.wait_us)
            begin
                $error("wait_us: expected %0d, got %0d", want.wait_us, wait_us);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lcdnw_pkg::ADDR_W-1:0]    paddr;
    logic [lcdnw_pkg::DATA_W-1:0]    pwdata;
    logic [lcdnw_pkg::DATA_W-1:0]    prdata;
    logic                            pready;
    bit                              sender_calm;
    bit                              receiver_calm;
    lcd_pin_scoreboard               pins;

    lcdnw_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
    lcdnw_port_if                           lcd_ch ();

    lcd_nibble_write_sequencer_top #(.VALUE_BITS(VALUE_BITS)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .lcd     (lcd_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("lcd_nibble_write_sequencer_top regression: fail");
        $finish;
    end

    // Idle stretches come and go so that some runs of items see no gaps at all.
    function automatic int unsigned pick_gap(ref bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_request(logic [1:0] action, logic [VALUE_BITS-1:0] value);
        int unsigned gap;
        gap = pick_gap(sender_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= action;
        req_ch.value  <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pins.note_request(action, value);
    endtask

    // Drops valid and waits until every expected pin state has come out.
    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        while (pins.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pulse_wait(logic [15:0] hold);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lcdnw_pkg::REG_PULSE_WAIT, 2'b00};
        pwdata  <= {16'd0, hold};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pins.pulse_wait = hold;
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_number();
        case ($urandom_range(0, 5))
            0:       return VALUE_BITS'($urandom_range(0, 9));
            1:       return VALUE_BITS'($urandom_range(10, 999));
            2:       return $urandom_range(0, 1) ? '1 : '0;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic run_random_phase(int unsigned count);
        int unsigned           sent;
        int unsigned           roll;
        logic [1:0]            action;
        logic [VALUE_BITS-1:0] value;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                action = lcdnw_pkg::ACT_CMD;
            else if (roll < 55)
                action = lcdnw_pkg::ACT_CHAR;
            else if (roll < 92)
                action = lcdnw_pkg::ACT_NUM;
            else
                action = lcdnw_pkg::ACT_NONE;
            value = (action == lcdnw_pkg::ACT_NUM) ? pick_number() : VALUE_BITS'($urandom);
            send_request(action, value);
            if (action != lcdnw_pkg::ACT_NONE)
                sent++;
        end
        drain_requests();
    endtask

    // Pin-state side: random stalls, every accepted item checked in order.
    initial
    begin
        int unsigned gap;
        lcd_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap(receiver_calm);
            if (gap > 0)
            begin
                lcd_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            lcd_ch.ready <= 1'b1;
            @(posedge clk);
            while (!lcd_ch.valid)
                @(posedge clk);
            pins.check_pin_state(lcd_ch.port_value, lcd_ch.wait_us, lcd_ch.last);
        end
    end

    initial
    begin
        pins          = new();
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_ch.valid  = 1'b0;
        req_ch.action = lcdnw_pkg::ACT_CMD;
        req_ch.value  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset hold time.
        send_request(lcdnw_pkg::ACT_CMD, 16'h0000);
        send_request(lcdnw_pkg::ACT_CMD, 16'hFFFF);
        send_request(lcdnw_pkg::ACT_CMD, 16'h0028);
        send_request(lcdnw_pkg::ACT_CHAR, 16'h0041);
        send_request(lcdnw_pkg::ACT_CHAR, 16'hFF00);
        send_request(lcdnw_pkg::ACT_CHAR, 16'h5AA5);
        send_request(lcdnw_pkg::ACT_NONE, 16'hFFFF);
        send_request(lcdnw_pkg::ACT_NONE, 16'h0000);
        send_request(lcdnw_pkg::ACT_NUM, 16'd0);
        send_request(lcdnw_pkg::ACT_NUM, 16'd9);
        send_request(lcdnw_pkg::ACT_NUM, 16'd10);
        send_request(lcdnw_pkg::ACT_NUM, 16'd100);
        send_request(lcdnw_pkg::ACT_NUM, 16'd12345);
        send_request(lcdnw_pkg::ACT_NUM, 16'd65535);
        send_request(lcdnw_pkg::ACT_NUM, 16'd40000);
        drain_requests();

        // A zero hold time must appear on the pin states as written.
        write_pulse_wait(16'd0);
        send_request(lcdnw_pkg::ACT_CHAR, 16'h0030);
        send_request(lcdnw_pkg::ACT_NUM, 16'd7);
        run_random_phase(RANDOM_PHASE);

        write_pulse_wait(16'hFFFF);
        run_random_phase(RANDOM_PHASE);

        write_pulse_wait(16'd1);
        run_random_phase(RANDOM_PHASE);

        write_pulse_wait(16'($urandom_range(2, 65534)));
        run_random_phase(RANDOM_PHASE);

        write_pulse_wait(lcdnw_pkg::PULSE_WAIT_RESET);
        run_random_phase(RANDOM_PHASE);

        if (pins.errors == 0 && pins.outstanding() == 0)
            $display("lcd_nibble_write_sequencer_top regression: pass");
        else
            $display("lcd_nibble_write_sequencer_top regression: fail");
        $finish;
    end
endmodule
